[design/lwah_pkg.sv]
// ----------------------------------------------------------------------------
// lwah_pkg
// Shared widths, codes and types for the lattice walk block.
// ----------------------------------------------------------------------------
`default_nettype none

package lwah_pkg;

    localparam int POS_W      = 16;   // cell index of a particle
    localparam int SIDE_W     = 9;    // grid_side / hole_divisor registers
    localparam int IDX_W      = 8;    // particle_index field
    localparam int DIR_W      = 3;    // direction field
    localparam int CNT_OUT_W  = 9;    // particle_count field
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int MAX_SIDE          = 256;
    localparam int MAX_PARTICLES_DEF = 256;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;
    localparam logic [SIDE_W-1:0] DIV_RESET  = 9'd2;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_ENABLE  = 2'd2;

    // command broadcast along the row of cells
    typedef struct packed {
        logic              load;   // write data into the addressed cell
        logic              shift;  // cells at or above addr take their upper neighbor
        logic [POS_W-1:0]  data;
    } cell_cmd_t;

endpackage

`default_nettype wire

[design/lwah_cell.sv]
// ----------------------------------------------------------------------------
// lwah_cell
// One slot of the particle table: holds a position, loads it when addressed,
// takes the upper neighbor's position on a compaction shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lwah_cell #(
    parameter int AW    = 8,
    parameter int INDEX = 0
) (
    input  wire logic                         clk,
    input  wire logic [AW-1:0]                addr,
    input  wire lwah_pkg::cell_cmd_t          cmd,
    input  wire logic [lwah_pkg::POS_W-1:0]   nbr_pos,
    output logic      [lwah_pkg::POS_W-1:0]   pos,
    output logic      [lwah_pkg::POS_W-1:0]   rd_data
);

    logic [lwah_pkg::POS_W-1:0] pos_reg;
    logic [lwah_pkg::POS_W-1:0] pos_next;
    logic                       hit;

    assign hit = (addr == AW'(INDEX));

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load && hit)
        begin
            pos_next = cmd.data;
        end
        else if (cmd.shift && (AW'(INDEX) >= addr))
        begin
            pos_next = nbr_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign pos     = pos_reg;
    // gated so the top can OR all cells into one read word
    assign rd_data = hit ? pos_reg : '0;

endmodule

`default_nettype wire

[design/lwah_div.sv]
// ----------------------------------------------------------------------------
// lwah_div
// Restoring divider, one quotient bit per cycle, 16-bit dividend by 9-bit
// divisor. done pulses for one cycle; results hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module lwah_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lwah_pkg::POS_W-1:0]    dividend,
    input  wire logic [lwah_pkg::SIDE_W-1:0]   divisor,
    output logic                               done,
    output logic      [lwah_pkg::POS_W-1:0]    quotient,
    output logic      [lwah_pkg::SIDE_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(lwah_pkg::POS_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(lwah_pkg::POS_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [lwah_pkg::POS_W-1:0]    quo_reg;
    logic [lwah_pkg::SIDE_W-1:0]   rem_reg;
    logic [lwah_pkg::SIDE_W-1:0]   dvs_reg;

    logic [lwah_pkg::SIDE_W:0]     shifted;
    logic [lwah_pkg::SIDE_W:0]     diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[lwah_pkg::POS_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[lwah_pkg::POS_W-2:0], fits};
            rem_reg <= fits ? diff[lwah_pkg::SIDE_W-1:0] : shifted[lwah_pkg::SIDE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[design/lattice_walk_with_absorbing_hole_top.sv]
// ----------------------------------------------------------------------------
// lattice_walk_with_absorbing_hole_top
// Particle table on a wrapping square lattice with an optional absorbing
// hole on the right edge; append and single-step move items.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  s_axis   | in        | tuser: func; tdata: particle_index, direction, load_position
//  m_axis   | out       | tuser: removed, ignored; tdata: new_position, particle_count
//  cfg      | in        | index 0 grid_side, 1 hole_divisor, 2 hole_enable
//
//  Append and rejected items go from accept through S_DONE to the result word.
//  A move goes through a cell read, two divider passes for column and row,
//  then the step, the write-back and the result word.
//  One item is in flight; the next is accepted while a result word waits.
//  The table itself has no reset; only the count and control are cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_walk_with_absorbing_hole_top #(
    parameter int MAX_PARTICLES = lwah_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [7:0] particle_index, [10:8] direction,
                                             // [26:11] load_position, [31:27] zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] func

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [15:0] new_position, [24:16] particle_count,
                                             // [31:25] zero
    output logic      [1:0]  m_axis_tuser,   // [0] removed, [1] ignored

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW   = $clog2(MAX_PARTICLES + 1);
    localparam int CMPW = (CW > lwah_pkg::IDX_W) ? CW : lwah_pkg::IDX_W;
    localparam int PW   = lwah_pkg::POS_W;
    localparam int SW   = lwah_pkg::SIDE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // ---------------- configuration ----------------
    logic [SW-1:0] grid_side_reg;
    logic [SW-1:0] hole_divisor_reg;
    logic          hole_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg    <= lwah_pkg::SIDE_RESET;
            hole_divisor_reg <= lwah_pkg::DIV_RESET;
            hole_enable_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lwah_pkg::REG_GRID_SIDE:    grid_side_reg    <= cfg_data;
                lwah_pkg::REG_HOLE_DIVISOR: hole_divisor_reg <= cfg_data;
                lwah_pkg::REG_HOLE_ENABLE:  hole_enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] side_eff;
    logic [SW-1:0] div_eff;

    always_comb
    begin
        if (grid_side_reg < SW'(2))
            side_eff = SW'(2);
        else if (grid_side_reg > SW'(lwah_pkg::MAX_SIDE))
            side_eff = SW'(lwah_pkg::MAX_SIDE);
        else
            side_eff = grid_side_reg;
        div_eff = (hole_divisor_reg == '0) ? SW'(1) : hole_divisor_reg;
    end

    // ---------------- input fields ----------------
    logic                          in_func;
    logic [lwah_pkg::IDX_W-1:0]    in_idx;
    logic [lwah_pkg::DIR_W-1:0]    in_dir;
    logic [PW-1:0]                 in_load;

    assign in_func = s_axis_tuser[0];
    assign in_idx  = s_axis_tdata[7:0];
    assign in_dir  = s_axis_tdata[10:8];
    assign in_load = s_axis_tdata[26:11];

    // ---------------- control state ----------------
    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [CW-1:0]                 count_reg;
    logic [AW-1:0]                 idx_reg;
    logic [lwah_pkg::DIR_W-1:0]    dir_reg;

    logic [PW-1:0]                 res_pos_reg;
    logic                          res_rem_reg;
    logic                          res_ign_reg;

    logic                          m_valid_reg;
    logic [PW-1:0]                 m_pos_reg;
    logic                          m_rem_reg;
    logic                          m_ign_reg;
    logic [lwah_pkg::CNT_OUT_W-1:0] m_cnt_reg;

    logic [SW-1:0]                 col_reg;
    logic [SW-1:0]                 row_reg;
    logic [SW-1:0]                 new_row_reg;
    logic [SW-1:0]                 new_col_reg;
    logic [2*SW-1:0]               hole_prod_reg;
    logic                          edge_right_reg;

    logic accept;
    logic table_full;
    logic idx_bad;
    logic out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign table_full    = (count_reg >= CW'(MAX_PARTICLES));
    assign idx_bad       = (CMPW'(in_idx) >= CMPW'(count_reg));
    assign out_free      = !m_valid_reg || m_axis_tready;

    // ---------------- divider ----------------
    logic          div_start;
    logic [PW-1:0] div_dividend;
    logic          div_done;
    logic [PW-1:0] div_quo;
    logic [SW-1:0] div_rem;
    logic [PW-1:0] rd_word;

    assign div_start    = (state_reg == S_READ) || ((state_reg == S_DIV1) && div_done);
    assign div_dividend = (state_reg == S_READ) ? rd_word : div_quo;

    lwah_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (side_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------- step and write-back ----------------
    logic [SW-1:0]   side_m1;
    logic [SW-1:0]   step_row;
    logic [SW-1:0]   step_col;
    logic [2*SW-1:0] new_pos_full;
    logic [PW-1:0]   new_pos;
    logic            hole_hit;

    assign side_m1 = side_eff - 1'b1;

    always_comb
    begin
        step_row = row_reg;
        step_col = col_reg;
        case (dir_reg)
            lwah_pkg::DIR_UP:    step_row = (row_reg != '0) ? row_reg - 1'b1 : side_m1;
            lwah_pkg::DIR_DOWN:  step_row = (row_reg != side_m1) ? row_reg + 1'b1 : '0;
            lwah_pkg::DIR_LEFT:  step_col = (col_reg != '0) ? col_reg - 1'b1 : side_m1;
            lwah_pkg::DIR_RIGHT: step_col = (col_reg != side_m1) ? col_reg + 1'b1 : '0;
            default: ;
        endcase
    end

    assign new_pos_full = new_row_reg * side_eff + {{SW{1'b0}}, new_col_reg};
    assign new_pos      = new_pos_full[PW-1:0];
    // row >= side-1-side/div  <=>  side >= div*(side-1-row)
    assign hole_hit     = hole_enable_reg && edge_right_reg
                          && ({{SW{1'b0}}, side_eff} >= hole_prod_reg);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV1) && div_done)
            col_reg <= div_rem;
        if ((state_reg == S_DIV2) && div_done)
            row_reg <= div_rem;
        if (state_reg == S_CALC)
        begin
            new_row_reg    <= step_row;
            new_col_reg    <= step_col;
            hole_prod_reg  <= (2*SW)'(div_eff) * (2*SW)'(side_m1 - row_reg);
            edge_right_reg <= (dir_reg == lwah_pkg::DIR_RIGHT) && (col_reg == side_m1);
        end
    end

    // ---------------- row of cells ----------------
    lwah_pkg::cell_cmd_t cmd;
    logic [AW-1:0]       cell_addr;
    logic [PW-1:0]       cell_pos [MAX_PARTICLES];
    logic [PW-1:0]       cell_rd  [MAX_PARTICLES];

    assign cell_addr = (state_reg == S_IDLE) ? count_reg[AW-1:0] : idx_reg;

    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.shift = 1'b0;
        cmd.data  = new_pos;
        if (state_reg == S_IDLE)
        begin
            cmd.load = accept && (in_func == lwah_pkg::FUNC_LOAD) && !table_full;
            cmd.data = in_load;
        end
        else if (state_reg == S_WB)
        begin
            cmd.load  = !hole_hit;
            cmd.shift = hole_hit;
        end
    end

    for (genvar g = 0; g < MAX_PARTICLES; g++)
    begin : g_cell
        logic [PW-1:0] nbr;
        if (g == MAX_PARTICLES - 1)
        begin : g_last
            assign nbr = cell_pos[g];
        end
        else
        begin : g_mid
            assign nbr = cell_pos[g+1];
        end

        lwah_cell #(
            .AW    (AW),
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .addr    (cell_addr),
            .cmd     (cmd),
            .nbr_pos (nbr),
            .pos     (cell_pos[g]),
            .rd_data (cell_rd[g])
        );
    end

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < MAX_PARTICLES; i++)
            rd_word = rd_word | cell_rd[i];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == lwah_pkg::FUNC_MOVE && !idx_bad)
                        state_next = S_READ;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ: state_next = S_DIV1;
            S_DIV1: if (div_done) state_next = S_DIV2;
            S_DIV2: if (div_done) state_next = S_CALC;
            S_CALC: state_next = S_WB;
            S_WB:   state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load && (state_reg == S_IDLE))
                count_reg <= count_reg + 1'b1;
            else if ((state_reg == S_WB) && hole_hit)
                count_reg <= count_reg - 1'b1;

            if ((state_reg == S_DONE) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg     <= AW'(in_idx);
            dir_reg     <= in_dir;
            res_rem_reg <= 1'b0;
            if (in_func == lwah_pkg::FUNC_LOAD)
            begin
                res_ign_reg <= table_full;
                res_pos_reg <= table_full ? '0 : in_load;
            end
            else
            begin
                res_ign_reg <= idx_bad;
                res_pos_reg <= '0;
            end
        end
        else if (state_reg == S_WB)
        begin
            res_rem_reg <= hole_hit;
            res_pos_reg <= hole_hit ? '0 : new_pos;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            m_pos_reg <= res_pos_reg;
            m_rem_reg <= res_rem_reg;
            m_ign_reg <= res_ign_reg;
            m_cnt_reg <= lwah_pkg::CNT_OUT_W'(count_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_cnt_reg, m_pos_reg};
    assign m_axis_tuser  = {m_ign_reg, m_rem_reg};

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the lattice walk block: directed edge cases, then
// random append/move traffic over many lattice and hole settings, each
// result word checked against an in-bench particle table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                          func;
        logic [lwah_pkg::IDX_W-1:0]    idx;
        logic [lwah_pkg::DIR_W-1:0]    dir;
        logic [lwah_pkg::POS_W-1:0]    load;
    } walk_cmd_t;

    typedef struct packed {
        logic [lwah_pkg::POS_W-1:0]     pos;
        logic                           removed;
        logic                           ignored;
        logic [lwah_pkg::CNT_OUT_W-1:0] count;
    } walk_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [lwah_pkg::CFG_IDX_W-1:0]  cfg_index = lwah_pkg::REG_GRID_SIDE;
    logic [lwah_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    walk_cmd_t    walk_cmds[$];
    walk_report_t expected_reports[$];
    walk_cmd_t    offered;

    // model of the particle table and its registers
    logic [lwah_pkg::POS_W-1:0]  cell_pos [lwah_pkg::MAX_PARTICLES_DEF];
    int                          tab_count = 0;
    logic [lwah_pkg::SIDE_W-1:0] side_reg = lwah_pkg::SIDE_RESET;
    logic [lwah_pkg::SIDE_W-1:0] div_reg = lwah_pkg::DIV_RESET;
    logic                        hole_en = 1'b0;

    int   send_idle_pct = 29;
    int   recv_idle_pct = 81;
    int   mismatches = 0;
    int   queued = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;

    lattice_walk_with_absorbing_hole_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] idx, [10:8] dir, [26:11] load
        .s_axis_tuser  (s_axis_tuser),   // [0] func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] new_position, [24:16] particle_count
        .m_axis_tuser  (m_axis_tuser),   // [0] removed, [1] ignored
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one accepted word to the table model and queues its report.
    function automatic void step_particle_table(input walk_cmd_t c);
        walk_report_t r;
        int unsigned  side, div, pos, row, col, k;
        int           hole_top;
        r = '0;
        if (c.func == lwah_pkg::FUNC_LOAD)
        begin
            if (tab_count >= lwah_pkg::MAX_PARTICLES_DEF)
                r.ignored = 1'b1;
            else
            begin
                cell_pos[tab_count] = c.load;
                tab_count++;
                r.pos = c.load;
            end
        end
        else if (c.idx >= tab_count)
        begin
            r.ignored = 1'b1;
        end
        else
        begin
            side = (side_reg < 2) ? 2
                 : (side_reg > lwah_pkg::MAX_SIDE) ? lwah_pkg::MAX_SIDE : side_reg;
            div  = (div_reg == 0) ? 1 : div_reg;
            pos  = cell_pos[c.idx] % (side * side);
            row  = pos / side;
            col  = pos % side;
            case (c.dir)
                lwah_pkg::DIR_UP:   pos = (row != 0) ? pos - side : pos + (side - 1) * side;
                lwah_pkg::DIR_DOWN: pos = (row != side - 1) ? pos + side : col;
                lwah_pkg::DIR_LEFT: pos = (col != 0) ? pos - 1 : pos + side - 1;
                lwah_pkg::DIR_RIGHT:
                begin
                    // hole rows start here; negative means the whole edge
                    hole_top = int'(side) - 1 - int'(side / div);
                    if (col != side - 1)
                        pos = pos + 1;
                    else if (hole_en && int'(row) >= hole_top)
                    begin
                        for (k = 32'(c.idx); k + 1 < tab_count; k++)
                            cell_pos[k] = cell_pos[k + 1];
                        tab_count--;
                        r.removed = 1'b1;
                    end
                    else
                        pos = row * side;
                end
                default: ;
            endcase
            if (!r.removed)
            begin
                cell_pos[c.idx] = pos[lwah_pkg::POS_W-1:0];
                r.pos = pos[lwah_pkg::POS_W-1:0];
            end
        end
        r.count = tab_count[lwah_pkg::CNT_OUT_W-1:0];
        expected_reports.push_back(r);
    endfunction

    function automatic void queue_append(input logic [lwah_pkg::POS_W-1:0] p);
        walk_cmd_t c;
        c = '{func: lwah_pkg::FUNC_LOAD, idx: 8'($urandom), dir: 3'($urandom),
              load: p};
        walk_cmds.push_back(c);
        queued++;
    endfunction

    function automatic void queue_step(input logic [lwah_pkg::IDX_W-1:0] i,
                                       input logic [lwah_pkg::DIR_W-1:0] d);
        walk_cmd_t c;
        c = '{func: lwah_pkg::FUNC_MOVE, idx: i, dir: d, load: 16'($urandom)};
        walk_cmds.push_back(c);
        queued++;
    endfunction

    // input side: offer words from walk_cmds, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                step_particle_table(offered);
            if (walk_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                offered = walk_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, offered.load, offered.dir, offered.idx};
                s_axis_tuser  <= offered.func;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // output side: random ready, compare each result word in order
    always @(posedge clk or negedge rst_n)
    begin : result_check
        walk_report_t got, want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pos     = m_axis_tdata[15:0];
                got.count   = m_axis_tdata[24:16];
                got.removed = m_axis_tuser[0];
                got.ignored = m_axis_tuser[1];
                if (expected_reports.size() == 0)
                begin
                    $error("result word with nothing expected: pos %0d count %0d",
                           got.pos, got.count);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.pos !== want.pos)
                    begin
                        $error("new_position: expected %0d, got %0d", want.pos, got.pos);
                        mismatches++;
                    end
                    if (got.removed !== want.removed)
                    begin
                        $error("removed: expected %0d, got %0d", want.removed, got.removed);
                        mismatches++;
                    end
                    if (got.ignored !== want.ignored)
                    begin
                        $error("ignored: expected %0d, got %0d", want.ignored, got.ignored);
                        mismatches++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("particle_count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (walk_cmds.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [lwah_pkg::CFG_IDX_W-1:0] index,
                             input logic [lwah_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            lwah_pkg::REG_GRID_SIDE:    side_reg = value;
            lwah_pkg::REG_HOLE_DIVISOR: div_reg = value;
            lwah_pkg::REG_HOLE_ENABLE:  hole_en = value[0];
            default: ;
        endcase
    endtask

    task automatic set_lattice(input int side, input int div, input int en);
        wait_idle();
        write_reg(lwah_pkg::REG_GRID_SIDE, 9'(side));
        write_reg(lwah_pkg::REG_HOLE_DIVISOR, 9'(div));
        write_reg(lwah_pkg::REG_HOLE_ENABLE, 9'(en));
        @(negedge clk);
    endtask

    // mostly moves of live particles, some appends, some junk
    task automatic random_batch(input int n);
        int est, side, cells, roll, i;
        logic [lwah_pkg::POS_W-1:0] p;
        logic [lwah_pkg::DIR_W-1:0] d;
        est   = tab_count;
        side  = (side_reg < 2) ? 2
              : (side_reg > lwah_pkg::MAX_SIDE) ? lwah_pkg::MAX_SIDE : side_reg;
        cells = side * side;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            d = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
            if (roll < 20 || (est == 0 && roll < 70))
            begin
                p = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, cells - 1));
                queue_append(p);
                if (est < lwah_pkg::MAX_PARTICLES_DEF)
                    est++;
            end
            else if (roll < 94 && est > 0)
                queue_step(8'($urandom_range(0, est - 1)), d);
            else
                queue_step(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        int phase, b, n, side, div, en;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: side 256, no hole
        queue_step(8'd0, lwah_pkg::DIR_UP);         // empty table
        queue_append(16'd0);
        queue_append(16'hFFFF);
        queue_append(16'd257);
        queue_step(8'd0, lwah_pkg::DIR_UP);         // wrap top to bottom
        queue_step(8'd0, lwah_pkg::DIR_DOWN);       // wrap bottom to top
        queue_step(8'd0, lwah_pkg::DIR_LEFT);       // wrap left edge
        queue_step(8'd1, lwah_pkg::DIR_RIGHT);      // right edge wraps, hole off
        queue_step(8'd2, lwah_pkg::DIR_NONE);
        queue_step(8'd2, 3'd5);
        queue_step(8'd2, 3'd6);
        queue_step(8'd2, 3'd7);
        queue_step(8'd3, lwah_pkg::DIR_UP);         // index equal to count
        queue_step(8'd255, lwah_pkg::DIR_DOWN);
        queue_step(8'd2, lwah_pkg::DIR_RIGHT);

        // side 4, divisor zero: the hole covers the whole right edge
        set_lattice(4, 0, 1);
        queue_step(8'd0, lwah_pkg::DIR_RIGHT);      // stored 255 is off lattice, removed
        queue_step(8'd0, lwah_pkg::DIR_LEFT);
        queue_step(8'd1, lwah_pkg::DIR_RIGHT);
        queue_step(8'd1, lwah_pkg::DIR_RIGHT);      // removes the last entry

        // side clamps to 256, hole rows 191..255
        set_lattice(511, 4, 1);
        queue_append(16'(191 * 256 + 255));
        queue_step(8'd1, lwah_pkg::DIR_RIGHT);
        queue_append(16'(190 * 256 + 255));
        queue_step(8'd1, lwah_pkg::DIR_RIGHT);
        wait_idle();

        phase = 0;
        while (queued < 2100)
        begin
            if (queued < 700)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 81;
            end
            else if (queued < 1400)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0:
                begin
                    side = 256; div = 2;   en = 1;
                end
                1:
                begin
                    side = 2;   div = 1;   en = 1;
                end
                2:
                begin
                    side = 0;   div = 0;   en = 1;
                end
                3:
                begin
                    side = 511; div = 256; en = 1;
                end
                4:
                begin
                    side = 16;  div = 3;   en = 0;
                end
                5:
                begin
                    side = 2;   div = 1;   en = 1;
                end
                6:
                begin
                    side = 1;   div = 3;   en = 1;
                end
                default:
                begin
                    side = $urandom_range(0, 1) ? $urandom_range(2, 20) : $urandom_range(0, 511);
                    div  = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 511);
                    en   = ($urandom_range(0, 3) != 0) ? 1 : 0;
                end
            endcase
            set_lattice(side, div, en);

            if (phase == 4)
            begin
                // fill the table past full, then move the top entries
                n = lwah_pkg::MAX_PARTICLES_DEF - tab_count + 4;
                repeat (n) queue_append(16'($urandom_range(0, 65535)));
                repeat (60) queue_step(8'($urandom_range(192, 255)), 3'($urandom_range(1, 4)));
                wait_idle();
            end
            else if (phase == 5)
            begin
                // every right-edge exit is removed: long table compactions
                repeat (240) queue_step(8'($urandom_range(0, 3)), lwah_pkg::DIR_RIGHT);
                wait_idle();
            end
            else
            begin
                for (b = 0; b < 3; b++)
                begin
                    random_batch(50);
                    if (phase == 1 && b == 1)
                    begin
                        @(posedge clk);
                        hold_req <= 1'b1;
                        @(posedge clk);
                        hold_req <= 1'b0;
                    end
                    wait_idle();
                end
            end
            phase++;
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
